// ===== src/stba_pkg.sv =====
// Shared constants for the triangle area sorter.
`timescale 1ns / 1ps
`default_nettype none

package stba_pkg;

    // Default build-time sizes
    localparam int MAX_TRIANGLES_DEF = 16;
    localparam int COORD_BITS_DEF    = 16;

    // Stream field layout
    localparam int FIELD_W     = 16;                      // one vertex coordinate
    localparam int NUM_COORDS  = 6;                       // ax, ay, bx, by, cx, cy
    localparam int VERT_W      = NUM_COORDS * FIELD_W;    // packed vertex fields
    localparam int OUT_AREA_W  = 33;                      // double_area on the bus
    localparam int S_TDATA_W   = VERT_W;
    localparam int M_TDATA_RAW = VERT_W + OUT_AREA_W;
    localparam int M_TDATA_W   = ((M_TDATA_RAW + 7) / 8) * 8;

    // Working width for coordinate extension and area truncation
    localparam int EXT_W  = 32;
    localparam int WIDE_W = 64;

endpackage : stba_pkg

`default_nettype wire

// ===== src/stba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module stba_ram #(
    parameter  int WIDTH  = 8,
    parameter  int DEPTH  = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule : stba_ram

`default_nettype wire

// ===== src/stba_area.sv =====
// Twice-area unit: one shared signed multiplier stepped by a small sequencer.
`timescale 1ns / 1ps
`default_nettype none

module stba_area #(
    parameter  int COORD_BITS = stba_pkg::COORD_BITS_DEF,
    localparam int AREA_W     = 2 * COORD_BITS + 2
) (
    input  wire logic                                               aclk,
    input  wire logic                                               aresetn,
    input  wire logic                                               start,
    input  wire logic [stba_pkg::NUM_COORDS-1:0][COORD_BITS-1:0]    coords,
    output logic                                                    done,
    output logic      [AREA_W-1:0]                                  area
);

    import stba_pkg::*;

    localparam int D_W = COORD_BITS + 1;

    typedef enum logic [2:0] {
        A_IDLE,
        A_DIFF,
        A_MUL1,
        A_MUL2,
        A_ABS
    } area_state_t;

    area_state_t               state_reg, state_next;
    logic signed [D_W-1:0]     ux_reg, ux_next;
    logic signed [D_W-1:0]     uy_reg, uy_next;
    logic signed [D_W-1:0]     wx_reg, wx_next;
    logic signed [D_W-1:0]     wy_reg, wy_next;
    logic signed [AREA_W-1:0]  p1_reg, p1_next;
    logic signed [AREA_W-1:0]  p2_reg, p2_next;
    logic        [AREA_W-1:0]  area_reg, area_next;
    logic                      done_reg, done_next;

    logic signed [COORD_BITS-1:0] ax_s, ay_s, bx_s, by_s, cx_s, cy_s;
    logic signed [D_W-1:0]        mul_a, mul_b;
    logic signed [AREA_W-1:0]     prod;

    assign ax_s = coords[0];
    assign ay_s = coords[1];
    assign bx_s = coords[2];
    assign by_s = coords[3];
    assign cx_s = coords[4];
    assign cy_s = coords[5];

    // Shared multiplier: ux*wy on the first pass, uy*wx on the second
    assign mul_a = (state_reg == A_MUL1) ? ux_reg : uy_reg;
    assign mul_b = (state_reg == A_MUL1) ? wy_reg : wx_reg;
    assign prod  = AREA_W'(mul_a) * AREA_W'(mul_b);

    // Sequencer
    always_comb begin
        state_next = state_reg;
        ux_next    = ux_reg;
        uy_next    = uy_reg;
        wx_next    = wx_reg;
        wy_next    = wy_reg;
        p1_next    = p1_reg;
        p2_next    = p2_reg;
        area_next  = area_reg;
        done_next  = 1'b0;
        case (state_reg)
            A_IDLE: begin
                if (start) begin
                    state_next = A_DIFF;
                end
            end
            A_DIFF: begin
                ux_next    = D_W'(bx_s) - D_W'(ax_s);
                uy_next    = D_W'(by_s) - D_W'(ay_s);
                wx_next    = D_W'(cx_s) - D_W'(ax_s);
                wy_next    = D_W'(cy_s) - D_W'(ay_s);
                state_next = A_MUL1;
            end
            A_MUL1: begin
                p1_next    = prod;
                state_next = A_MUL2;
            end
            A_MUL2: begin
                p2_next    = prod;
                state_next = A_ABS;
            end
            A_ABS: begin
                // |p1 - p2| without a negate after the subtract
                area_next  = (p1_reg >= p2_reg) ? (p1_reg - p2_reg) : (p2_reg - p1_reg);
                done_next  = 1'b1;
                state_next = A_IDLE;
            end
            default: begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        ux_reg   <= ux_next;
        uy_reg   <= uy_next;
        wx_reg   <= wx_next;
        wy_reg   <= wy_next;
        p1_reg   <= p1_next;
        p2_reg   <= p2_next;
        area_reg <= area_next;
        if (!aresetn) begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign done = done_reg;
    assign area = area_reg;

endmodule : stba_area

`default_nettype wire

// ===== src/sort_triangles_by_area.sv =====
// Top level: loads triangles, keeps them sorted by area in a RAM, drains on tlast.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tdata: ax..cy, s_tlast: last_in
//  m_      | out | m_tvalid/m_tready  | m_tdata: out_ax..out_cy, double_area;
//          |     |                    | m_tlast: last_out, m_tuser: dropped
//
// An item goes through the twice-area unit (four steps, two of them on one shared
// multiplier, then its done flag), then is placed by shifting up every stored entry
// with a larger area, each shift being one read and one write of the RAM; a dropped
// item is not placed. A tlast item then drains the store, each result read, loaded
// and offered in turn, and each offer waits out any m_tready stall.
// Reset is synchronous on aresetn and empties the store; RAM contents are not cleared.
// s_tready is high only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module sort_triangles_by_area #(
    parameter int MAX_TRIANGLES = stba_pkg::MAX_TRIANGLES_DEF,
    parameter int COORD_BITS    = stba_pkg::COORD_BITS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // ax, ay, bx, by_coord, cx, cy (16 bits each, from bit 0 up)
    input  wire logic [stba_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                           s_tlast,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // out_ax, out_ay, out_bx, out_by, out_cx, out_cy (16 each), double_area (33), zero pad
    output logic      [stba_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                                m_tlast,
    // dropped
    output logic                                m_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready
);

    import stba_pkg::*;

    localparam int AREA_W  = 2 * COORD_BITS + 2;
    localparam int ENTRY_W = VERT_W + AREA_W;
    localparam int ADDR_W  = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
    localparam int CNT_W   = $clog2(MAX_TRIANGLES + 1);
    localparam int PAD_W   = M_TDATA_W - M_TDATA_RAW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_AREA,
        S_INS_RD,
        S_INS_CMP,
        S_DR_RD,
        S_DR_LOAD,
        S_DR_OUT
    } state_t;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         fill_reg, fill_next;
    logic                     ovf_reg, ovf_next;
    logic [CNT_W-1:0]         pos_reg, pos_next;
    logic [CNT_W-1:0]         k_reg, k_next;
    logic [S_TDATA_W-1:0]     in_reg, in_next;
    logic                     last_reg, last_next;
    logic [M_TDATA_W-1:0]     tdata_reg, tdata_next;
    logic                     tlast_reg, tlast_next;
    logic                     tuser_reg, tuser_next;

    logic                                    s_xfer;
    logic [NUM_COORDS-1:0][COORD_BITS-1:0]   cval;
    logic [NUM_COORDS-1:0][FIELD_W-1:0]      fout;
    logic                                    area_done;
    logic [AREA_W-1:0]                       new_area;
    logic [ENTRY_W-1:0]                      new_entry;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [ENTRY_W-1:0]    ram_wdata;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [ENTRY_W-1:0]    ram_rdata;
    logic [AREA_W-1:0]     rd_area;
    logic [WIDE_W-1:0]     rd_area_wide;
    logic [CNT_W-1:0]      pos_m1;
    logic [CNT_W-1:0]      k_p1;
    logic                  full;

    assign s_tready = (state_reg == S_IDLE);
    assign s_xfer   = s_tvalid && s_tready;

    // Coordinate views: low COORD_BITS of each field, sign-extended; bus copy is 16 bits
    for (genvar g = 0; g < NUM_COORDS; g++) begin : g_coord
        logic        [EXT_W-1:0]      raw_ext;
        logic signed [COORD_BITS-1:0] cv;
        logic signed [EXT_W-1:0]      cv_ext;
        assign raw_ext = EXT_W'(in_reg[g*FIELD_W +: FIELD_W]);
        assign cv      = raw_ext[COORD_BITS-1:0];
        assign cv_ext  = EXT_W'(cv);
        assign cval[g] = cv;
        assign fout[g] = cv_ext[FIELD_W-1:0];
    end

    stba_area #(
        .COORD_BITS (COORD_BITS)
    ) u_area (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (s_xfer),
        .coords  (cval),
        .done    (area_done),
        .area    (new_area)
    );

    stba_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TRIANGLES)
    ) u_store (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign new_entry    = {new_area, fout};
    assign rd_area      = ram_rdata[ENTRY_W-1 -: AREA_W];
    assign rd_area_wide = WIDE_W'(rd_area);
    assign pos_m1       = pos_reg - CNT_W'(1);
    assign k_p1         = k_reg + CNT_W'(1);
    assign full         = (fill_reg == CNT_W'(MAX_TRIANGLES));

    // Sequencer: area, insertion by shifting larger entries up, then drain
    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        ovf_next   = ovf_reg;
        pos_next   = pos_reg;
        k_next     = k_reg;
        in_next    = in_reg;
        last_next  = last_reg;
        tdata_next = tdata_reg;
        tlast_next = tlast_reg;
        tuser_next = tuser_reg;
        ram_we     = 1'b0;
        ram_waddr  = pos_reg[ADDR_W-1:0];
        ram_wdata  = new_entry;
        ram_raddr  = pos_m1[ADDR_W-1:0];
        case (state_reg)
            S_IDLE: begin
                k_next = '0;
                if (s_xfer) begin
                    in_next    = s_tdata;
                    last_next  = s_tlast;
                    state_next = S_AREA;
                end
            end
            S_AREA: begin
                if (area_done) begin
                    if (full) begin
                        ovf_next   = 1'b1;
                        state_next = last_reg ? S_DR_RD : S_IDLE;
                    end else begin
                        pos_next   = fill_reg;
                        state_next = S_INS_RD;
                    end
                end
            end
            S_INS_RD: begin
                if (pos_reg == '0) begin
                    ram_we     = 1'b1;
                    fill_next  = fill_reg + CNT_W'(1);
                    state_next = last_reg ? S_DR_RD : S_IDLE;
                end else begin
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                ram_we = 1'b1;
                if (rd_area > new_area) begin
                    // Larger entry moves up one place
                    ram_wdata  = ram_rdata;
                    pos_next   = pos_m1;
                    state_next = S_INS_RD;
                end else begin
                    fill_next  = fill_reg + CNT_W'(1);
                    state_next = last_reg ? S_DR_RD : S_IDLE;
                end
            end
            S_DR_RD: begin
                ram_raddr  = k_reg[ADDR_W-1:0];
                state_next = S_DR_LOAD;
            end
            S_DR_LOAD: begin
                tdata_next = {{PAD_W{1'b0}}, rd_area_wide[OUT_AREA_W-1:0],
                              ram_rdata[VERT_W-1:0]};
                tlast_next = (k_p1 == fill_reg);
                tuser_next = ovf_reg;
                state_next = S_DR_OUT;
            end
            S_DR_OUT: begin
                if (m_tready) begin
                    k_next = k_p1;
                    if (tlast_reg) begin
                        fill_next  = '0;
                        ovf_next   = 1'b0;
                        state_next = S_IDLE;
                    end else begin
                        state_next = S_DR_RD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        pos_reg   <= pos_next;
        k_reg     <= k_next;
        in_reg    <= in_next;
        last_reg  <= last_next;
        tdata_reg <= tdata_next;
        tlast_reg <= tlast_next;
        tuser_reg <= tuser_next;
        if (!aresetn) begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign m_tvalid = (state_reg == S_DR_OUT);
    assign m_tdata  = tdata_reg;
    assign m_tlast  = tlast_reg;
    assign m_tuser  = tuser_reg;

endmodule : sort_triangles_by_area

`default_nettype wire

// ===== tb/sv/area_sort_checker.sv =====
// Checker for the triangle area sorter: predicts the sorted drain and compares every result.
`timescale 1ns / 1ps
`default_nettype none

module area_sort_checker
    import stba_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 s_tlast,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [M_TDATA_W-1:0] m_tdata,
    input  wire logic                 m_tlast,
    input  wire logic                 m_tuser,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    output int                        mismatches,
    output int                        outstanding,
    output int                        results_checked
);

    localparam int CAPACITY = MAX_TRIANGLES_DEF;
    localparam int CBITS    = COORD_BITS_DEF;

    typedef struct packed {
        logic [VERT_W-1:0]     verts;
        logic [OUT_AREA_W-1:0] dbl_area;
        logic                  last;
        logic                  dropped;
    } tri_entry_t;

    // Predictor state: the store kept in area order, plus the set's drop flag
    tri_entry_t sorted_store[$];
    logic       set_overflowed = 1'b0;
    // Results the block still owes, oldest first
    tri_entry_t owed_results[$];
    int         errs = 0;
    int         seen = 0;

    string coord_name [NUM_COORDS] = '{"ax", "ay", "bx", "by", "cx", "cy"};

    // Keep the low CBITS bits of a coordinate, sign-extended
    function automatic longint sext_coord(input logic [FIELD_W-1:0] raw);
        longint v;
        v = longint'({48'd0, raw}) & ((longint'(1) << CBITS) - 1);
        if (v[CBITS-1])
            v = v - (longint'(1) << CBITS);
        return v;
    endfunction

    // Exact |(b-a) x (c-a)|, masked to the bus width
    function automatic logic [OUT_AREA_W-1:0] twice_area(input logic [S_TDATA_W-1:0] d);
        longint p [NUM_COORDS];
        longint cr;
        for (int i = 0; i < NUM_COORDS; i++)
            p[i] = sext_coord(d[i*FIELD_W +: FIELD_W]);
        cr = (p[2] - p[0]) * (p[5] - p[1]) - (p[3] - p[1]) * (p[4] - p[0]);
        if (cr < 0)
            cr = -cr;
        return cr[OUT_AREA_W-1:0];
    endfunction

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            if (errs < 10)
                $display("mismatch on result %0d, %s: expected 0x%0h, got 0x%0h",
                         seen, name, want, got);
            errs++;
        end
    endtask

    always @(posedge aclk) begin : watch
        tri_entry_t want;
        tri_entry_t item;
        longint     v;
        int         pos;
        if (aresetn) begin
            // Result transfer: compare against the oldest owed result
            if (m_tvalid && m_tready) begin
                if (owed_results.size() == 0) begin
                    if (errs < 10)
                        $display("result %0d arrived with nothing owed: tdata 0x%0h",
                                 seen, m_tdata);
                    errs++;
                end else begin
                    want = owed_results.pop_front();
                    for (int i = 0; i < NUM_COORDS; i++)
                        check_field(coord_name[i], want.verts[i*FIELD_W +: FIELD_W],
                                    m_tdata[i*FIELD_W +: FIELD_W]);
                    check_field("double_area", want.dbl_area,
                                m_tdata[VERT_W +: OUT_AREA_W]);
                    check_field("pad", 0, m_tdata[M_TDATA_W-1:M_TDATA_RAW]);
                    check_field("last_out", want.last, m_tlast);
                    check_field("dropped", want.dropped, m_tuser);
                end
                seen++;
            end

            // Input transfer: stable insert, drain on tlast
            if (s_tvalid && s_tready) begin
                for (int i = 0; i < NUM_COORDS; i++) begin
                    v = sext_coord(s_tdata[i*FIELD_W +: FIELD_W]);
                    item.verts[i*FIELD_W +: FIELD_W] = v[FIELD_W-1:0];
                end
                item.dbl_area = twice_area(s_tdata);
                item.last     = 1'b0;
                item.dropped  = 1'b0;
                if (sorted_store.size() < CAPACITY) begin
                    pos = sorted_store.size();
                    while (pos > 0 && sorted_store[pos-1].dbl_area > item.dbl_area)
                        pos--;
                    sorted_store.insert(pos, item);
                end else begin
                    set_overflowed = 1'b1;
                end
                if (s_tlast) begin
                    foreach (sorted_store[k]) begin
                        want         = sorted_store[k];
                        want.last    = (k == sorted_store.size() - 1);
                        want.dropped = set_overflowed;
                        owed_results.push_back(want);
                    end
                    sorted_store.delete();
                    set_overflowed = 1'b0;
                end
            end
        end
        mismatches      <= errs;
        outstanding     <= owed_results.size();
        results_checked <= seen;
    end

endmodule : area_sort_checker

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Testbench top: drives triangle sets into the area sorter and gives the verdict.
`timescale 1ns / 1ps
`default_nettype none

module testbench;
    import stba_pkg::*;

    localparam int RAND_ITEMS  = 155;
    localparam int WDOG_LIMIT  = 4000;
    localparam int TAIL_CYCLES = 60;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic                 m_tuser;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;

    int mismatches;
    int outstanding;
    int results_checked;

    int src_idle_pct  = 22;
    int sink_idle_pct = 81;
    int tris_sent     = 0;
    int sets_sent     = 0;
    int tris_over     = 0;
    int quiet_cycles  = 0;

    sort_triangles_by_area DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    area_sort_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .m_tuser         (m_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Watchdog: cycles without any transfer on either channel
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results owed",
                     quiet_cycles, outstanding);
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [S_TDATA_W-1:0] pack_tri(input int a_x, a_y, b_x, b_y,
                                                       c_x, c_y);
        return {c_y[15:0], c_x[15:0], b_y[15:0], b_x[15:0], a_y[15:0], a_x[15:0]};
    endfunction

    // Full range, a small window (many ties and flat triangles), or the extremes
    function automatic int rand_coord(input int mode);
        case (mode)
            0: return int'($urandom_range(65535)) - 32768;
            1: return int'($urandom_range(8)) - 4;
            default: begin
                case ($urandom_range(3))
                    0: return -32768;
                    1: return 32767;
                    2: return 0;
                    default: return -1;
                endcase
            end
        endcase
    endfunction

    function automatic logic [S_TDATA_W-1:0] rand_tri();
        int pick;
        int mode;
        pick = $urandom_range(99);
        mode = (pick < 50) ? 0 : (pick < 80) ? 1 : 2;
        return pack_tri(rand_coord(mode), rand_coord(mode), rand_coord(mode),
                        rand_coord(mode), rand_coord(mode), rand_coord(mode));
    endfunction

    // One input transfer; called and returning at a rising edge
    task automatic send_tri(input logic [S_TDATA_W-1:0] d, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        tris_sent++;
    endtask

    task automatic note_set(input int n);
        sets_sent++;
        if (n > MAX_TRIANGLES_DEF)
            tris_over += n - MAX_TRIANGLES_DEF;
    endtask

    initial begin : stimulus
        int set_len;
        int pick;
        int rand_sent;
        int phase;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Single-triangle set with the largest area the coordinates allow
        send_tri(pack_tri(32767, -32768, -32768, -32768, 32767, 32767), 1'b1);
        note_set(1);

        // Mixed areas, ties and flat triangles: exercises shifts and stability
        send_tri(pack_tri(0, 0, 6, 0, 0, 6), 1'b0);
        send_tri(pack_tri(0, 0, 4, 0, 0, 3), 1'b0);
        send_tri(pack_tri(5, 5, 5, 5, 5, 5), 1'b0);
        send_tri(pack_tri(1, 1, 5, 1, 1, 4), 1'b0);
        send_tri(pack_tri(0, 0, 10, 10, -20, -20), 1'b0);
        send_tri(pack_tri(-32768, 32767, 32767, 32767, -32768, -32768), 1'b1);
        note_set(6);

        // Overfilled set: the last two transfers, tlast one included, are dropped
        for (int i = 0; i < 17; i++)
            send_tri(pack_tri(0, 0, (i % 6) * 5000, 0, 0, -((i % 4) * 7000 + 1)), 1'b0);
        send_tri(pack_tri(-32768, -32768, 32767, 32767, 32767, -32768), 1'b1);
        note_set(18);

        // Random sets: mostly small, some full, a few past capacity
        rand_sent = 0;
        while (rand_sent < RAND_ITEMS) begin
            phase = (rand_sent * 3) / RAND_ITEMS;
            case (phase)
                0: begin
                    src_idle_pct   = 22;
                    sink_idle_pct <= 81;
                end
                1: begin
                    src_idle_pct   = 81;
                    sink_idle_pct <= 22;
                end
                default: begin
                    src_idle_pct   = 0;
                    sink_idle_pct <= 0;
                end
            endcase
            pick = $urandom_range(99);
            if (pick < 80)
                set_len = $urandom_range(8, 1);
            else if (pick < 93)
                set_len = $urandom_range(16, 9);
            else
                set_len = $urandom_range(20, 17);
            for (int i = 0; i < set_len; i++)
                send_tri(rand_tri(), i == set_len - 1);
            note_set(set_len);
            rand_sent += set_len;
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        // Drain: wait for every owed result, then let the block settle
        do
            @(posedge aclk);
        while (outstanding != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d sets of %0d triangles, %0d of them past capacity",
                 sets_sent, tris_sent, tris_over);
        $display("%0d sorted results checked, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule : testbench

`default_nettype wire
